[rtl/gtm_pkg.sv]
package gtm_pkg;

   localparam int unsigned OPND_W = 32;
   localparam int unsigned ACC_W = 64;
   localparam int unsigned TILE_ELEMS = 4;
   localparam int unsigned REQ_DATA_W = 8 * OPND_W;
   localparam int unsigned RSP_DATA_W = TILE_ELEMS * OPND_W;
   localparam int unsigned MASK_W = 4;
   localparam int unsigned DEF_QUEUE_DEPTH = 4;

   // one outer-product step after the operand roles are settled
   typedef struct packed {
      logic                               last;
      logic [TILE_ELEMS-1:0][OPND_W-1:0]  old_c;   // column-major c00 c10 c01 c11
      logic signed [OPND_W-1:0]           y1;
      logic signed [OPND_W-1:0]           y0;
      logic signed [OPND_W-1:0]           x1;
      logic signed [OPND_W-1:0]           x0;
   } step_type;

endpackage

[rtl/gtm_front.sv]
module gtm_front (
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // a_first, a_second, b_first, b_second, old_c00, old_c10, old_c01, old_c11
   input  logic [gtm_pkg::REQ_DATA_W-1:0]      req_tdata,
   input  logic                                req_tlast,
   input  logic                                swap_operands,
   input  logic                                queue_ready,
   output logic                                push,
   output gtm_pkg::step_type                   step
);

   localparam int unsigned W = gtm_pkg::OPND_W;

   logic [W-1:0] a_first, a_second, b_first, b_second;

   assign a_first  = req_tdata[0*W +: W];
   assign a_second = req_tdata[1*W +: W];
   assign b_first  = req_tdata[2*W +: W];
   assign b_second = req_tdata[3*W +: W];

   assign req_tready = queue_ready;
   assign push = req_tvalid && queue_ready;

   always_comb begin
      // row-major C: B supplies the column vector, A the row vector
      if (swap_operands) begin
         step.x0 = b_first;
         step.x1 = b_second;
         step.y0 = a_first;
         step.y1 = a_second;
      end else begin
         step.x0 = a_first;
         step.x1 = a_second;
         step.y0 = b_first;
         step.y1 = b_second;
      end
      for (int k = 0; k < gtm_pkg::TILE_ELEMS; k++) begin
         step.old_c[k] = req_tdata[(4 + k)*W +: W];
      end
      step.last = req_tlast;
   end

endmodule

[rtl/gtm_queue.sv]
module gtm_queue #(
   parameter int unsigned DEPTH = gtm_pkg::DEF_QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  gtm_pkg::step_type  push_data,
   output logic               not_full,
   output logic               not_empty,
   input  logic               pop,
   output gtm_pkg::step_type  pop_data
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   gtm_pkg::step_type mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign not_full = (count_ff != FULL_CNT);
   assign not_empty = (count_ff != '0);
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assert property (@(posedge clock) disable iff (reset) count_ff <= FULL_CNT)
      else $error("queue count beyond depth");

   assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue count missed a push");

   assert property (@(posedge clock) disable iff (reset) pop |-> not_empty)
      else $error("queue popped while empty");

   assert property (@(posedge clock) disable iff (reset) push |-> not_full)
      else $error("queue pushed while full");

endmodule

[rtl/gtm_back.sv]
module gtm_back (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                step_valid,
   output logic                                step_ready,
   input  gtm_pkg::step_type                   step,
   input  logic signed [gtm_pkg::OPND_W-1:0]   beta_scale,
   input  logic [gtm_pkg::MASK_W-1:0]          write_mask,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // new_c00, new_c10, new_c01, new_c11
   output logic [gtm_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // write_mask
   output logic [gtm_pkg::MASK_W-1:0]          rsp_tuser
);

   localparam int unsigned W = gtm_pkg::OPND_W;
   localparam int unsigned AW = gtm_pkg::ACC_W;
   localparam int unsigned N = gtm_pkg::TILE_ELEMS;
   localparam int unsigned FRAC = 16;
   localparam int unsigned RW = AW - FRAC + 1;

   function automatic logic signed [AW-1:0] sat_add(input logic signed [AW-1:0] a,
                                                    input logic signed [AW-1:0] b);
      logic signed [AW-1:0] s;
      s = a + b;
      if (a[AW-1] == b[AW-1] && s[AW-1] != a[AW-1]) begin
         s = a[AW-1] ? {1'b1, {(AW-1){1'b0}}} : {1'b0, {(AW-1){1'b1}}};
      end
      return s;
   endfunction

   // Q32.32 to Q16.16, round half up, clamp to 32 bits
   function automatic logic [W-1:0] to_q16(input logic signed [AW-1:0] v);
      logic signed [RW-1:0] r;
      logic [W-1:0] q;
      r = $signed({v[AW-1], v[AW-1:FRAC]}) + $signed({{(RW-1){1'b0}}, v[FRAC-1]});
      if (r[RW-1:W-1] != {(RW-W+1){r[RW-1]}}) begin
         q = r[RW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      end else begin
         q = r[W-1:0];
      end
      return q;
   endfunction

   logic en;

   logic                  p_valid_ff;
   logic                  p_last_ff;
   logic signed [AW-1:0]  prod_ff  [N];
   logic signed [AW-1:0]  bprod_ff [N];

   logic signed [AW-1:0]  acc_ff [N];
   logic signed [AW-1:0]  acc_sum [N];

   logic                  t_valid_ff;
   logic signed [AW-1:0]  tile_ff  [N];
   logic signed [AW-1:0]  tbeta_ff [N];

   logic                  s_valid_ff;
   logic signed [AW-1:0]  sum_ff [N];

   logic                  rsp_valid_ff;
   logic [W-1:0]          rsp_c_ff [N];
   logic [gtm_pkg::MASK_W-1:0] rsp_mask_ff;

   logic signed [W-1:0] xv [2];
   logic signed [W-1:0] yv [2];
   logic signed [W-1:0] cv [N];

   // whole back end moves together; held only while a result waits
   assign en = !rsp_valid_ff || rsp_tready;
   assign step_ready = en;

   assign xv[0] = step.x0;
   assign xv[1] = step.x1;
   assign yv[0] = step.y0;
   assign yv[1] = step.y1;

   always_comb begin
      for (int k = 0; k < N; k++) begin
         cv[k] = step.old_c[k];
         acc_sum[k] = sat_add(acc_ff[k], prod_ff[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
         t_valid_ff <= 1'b0;
         s_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < N; k++) begin
            acc_ff[k] <= '0;
         end
      end else if (en) begin
         p_valid_ff <= step_valid;
         t_valid_ff <= p_valid_ff && p_last_ff;
         s_valid_ff <= t_valid_ff;
         rsp_valid_ff <= s_valid_ff;
         if (p_valid_ff) begin
            for (int k = 0; k < N; k++) begin
               acc_ff[k] <= p_last_ff ? '0 : acc_sum[k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_last_ff <= step.last;
         for (int j = 0; j < 2; j++) begin
            for (int i = 0; i < 2; i++) begin
               prod_ff[i + 2*j] <= AW'(xv[i]) * AW'(yv[j]);
            end
         end
         for (int k = 0; k < N; k++) begin
            bprod_ff[k] <= AW'(beta_scale) * AW'(cv[k]);
            tile_ff[k] <= acc_sum[k];
            tbeta_ff[k] <= bprod_ff[k];
            // beta of zero gives a zero product, so the sum is the tile alone
            sum_ff[k] <= sat_add(tile_ff[k], tbeta_ff[k]);
            rsp_c_ff[k] <= to_q16(sum_ff[k]);
         end
         rsp_mask_ff <= write_mask;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser = rsp_mask_ff;
   always_comb begin
      for (int k = 0; k < N; k++) begin
         rsp_tdata[k*W +: W] = rsp_c_ff[k];
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      en && p_valid_ff && p_last_ff |=> acc_ff[0] == '0 && acc_ff[1] == '0 &&
                                         acc_ff[2] == '0 && acc_ff[3] == '0)
      else $error("accumulators not cleared after tile");

   assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(acc_ff[0]) && $stable(acc_ff[3]))
      else $error("accumulators moved during stall");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

endmodule

[rtl/gemm_tile_2x2_mac.sv]
// 2x2 outer-product tile accumulator, Q16.16 operands, 64-bit Q32.32 sums.
// req channel: one transaction per step; tdata carries the A pair, the B pair
// and the old C tile, tlast marks the final step of a run. Old C is only
// looked at on the final step.
// rsp channel: one transaction per run, sent after its final step; tdata holds
// the saturated Q16.16 tile column-major, tuser the write mask.
// csr port: beta_scale at 0x0, valid_rows at 0x4, valid_cols at 0x8,
// swap_operands at 0xC; write only while no run is in flight.
// Throughput is one step per clock while no result waits on rsp_tready, set by
// the four operand multipliers and the accumulator add feeding back on itself.
// From the final step's transaction to rsp_tvalid a step passes the queue,
// multiply, accumulate, beta add and round registers.
// A queue of QUEUE_DEPTH steps sits between the input handshake and the
// arithmetic. While a result waits with rsp_tready low the arithmetic holds and
// the queue fills; req_tready drops only once it is full.
// Reset clears the queue, the accumulators and the registers to beta 0,
// two rows, two columns, no swap.
module gemm_tile_2x2_mac #(
   parameter int unsigned QUEUE_DEPTH = gtm_pkg::DEF_QUEUE_DEPTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // a_first, a_second, b_first, b_second, old_c00, old_c10, old_c01, old_c11
   input  logic [gtm_pkg::REQ_DATA_W-1:0]      req_tdata,
   input  logic                                req_tlast,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // new_c00, new_c10, new_c01, new_c11
   output logic [gtm_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // write_mask
   output logic [gtm_pkg::MASK_W-1:0]          rsp_tuser,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [3:0]                          csr_paddr,
   input  logic [31:0]                         csr_pwdata,
   output logic [31:0]                         csr_prdata,
   output logic                                csr_pready
);

   localparam logic [1:0] REG_BETA = 2'd0;
   localparam logic [1:0] REG_ROWS = 2'd1;
   localparam logic [1:0] REG_COLS = 2'd2;
   localparam logic [1:0] REG_SWAP = 2'd3;

   logic signed [31:0] beta_ff;
   logic [1:0] rows_ff;
   logic [1:0] cols_ff;
   logic swap_ff;
   logic csr_write;
   logic [1:0] reg_sel;
   logic [gtm_pkg::MASK_W-1:0] mask;

   logic queue_ready, push, q_valid, q_pop, back_ready;
   gtm_pkg::step_type front_step, q_step;

   assign csr_pready = 1'b1;
   assign reg_sel = csr_paddr[3:2];
   assign csr_write = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         beta_ff <= '0;
         rows_ff <= 2'd2;
         cols_ff <= 2'd2;
         swap_ff <= 1'b0;
      end else if (csr_write) begin
         unique case (reg_sel)
            REG_BETA: beta_ff <= csr_pwdata;
            REG_ROWS: rows_ff <= csr_pwdata[1:0];
            REG_COLS: cols_ff <= csr_pwdata[1:0];
            REG_SWAP: swap_ff <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_BETA: csr_prdata = beta_ff;
         REG_ROWS: csr_prdata = {30'd0, rows_ff};
         REG_COLS: csr_prdata = {30'd0, cols_ff};
         REG_SWAP: csr_prdata = {31'd0, swap_ff};
         default: csr_prdata = '0;
      endcase
   end

   // a count of three behaves as two
   assign mask[0] = (rows_ff != 2'd0) && (cols_ff != 2'd0);
   assign mask[1] = rows_ff[1] && (cols_ff != 2'd0);
   assign mask[2] = (rows_ff != 2'd0) && cols_ff[1];
   assign mask[3] = rows_ff[1] && cols_ff[1];

   gtm_front u_front (
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tlast     (req_tlast),
      .swap_operands (swap_ff),
      .queue_ready   (queue_ready),
      .push          (push),
      .step          (front_step)
   );

   gtm_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (front_step),
      .not_full  (queue_ready),
      .not_empty (q_valid),
      .pop       (q_pop),
      .pop_data  (q_step)
   );

   assign q_pop = q_valid && back_ready;

   gtm_back u_back (
      .clock      (clock),
      .reset      (reset),
      .step_valid (q_valid),
      .step_ready (back_ready),
      .step       (q_step),
      .beta_scale (beta_ff),
      .write_mask (mask),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
